[sv/rrlp_pkg.sv]
package rrlp_pkg;

	localparam int DEFAULT_LED_COUNT = 32;

	localparam int LED_INDEX_W = 6;
	localparam int COLOR_W     = 8;
	localparam int VEL_W       = 5;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	localparam logic [COLOR_W-1:0] LOW_BRIGHTNESS_RST  = 8'd32;
	localparam logic [COLOR_W-1:0] HIGH_BRIGHTNESS_RST = 8'd255;
	localparam logic [VEL_W-1:0]   RED_VEL_RST         = 5'sd1;
	localparam logic [VEL_W-1:0]   GREEN_VEL_RST       = 5'sd2;
	localparam logic [VEL_W-1:0]   BLUE_VEL_RST        = 5'b11101;

	localparam int RECIP_SHIFT = 18;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LOW_BRIGHTNESS  = 3'd0,
		REG_HIGH_BRIGHTNESS = 3'd1,
		REG_RED_VELOCITY    = 3'd2,
		REG_GREEN_VELOCITY  = 3'd3,
		REG_BLUE_VELOCITY   = 3'd4
	} cfg_reg_t;

endpackage

[sv/rotating_ramp_led_pattern.sv]
// Channel   Handshake                 Payload
// tick      tick_valid / tick_stall   dim_select
// pixel     pixel_valid / pixel_stall led_index, red, green, blue, last_pixel
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Each tick yields LED_COUNT pixels, one per cycle from the frame counter while
// pixel_stall is low. The next tick is taken in the cycle the last pixel enters
// the output register. pixel_stall holds a valid output register and then
// freezes the frame counter. arst_n clears positions, toggle, frame and output
// control; registers take their reset values. cfg_ready is always high.
module rotating_ramp_led_pattern #(
	parameter int LED_COUNT = rrlp_pkg::DEFAULT_LED_COUNT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               tick_valid,
	output logic                               tick_stall,
	input  logic                               dim_select,
	output logic                               pixel_valid,
	input  logic                               pixel_stall,
	output logic [rrlp_pkg::LED_INDEX_W-1:0]   led_index,
	output logic [rrlp_pkg::COLOR_W-1:0]       red,
	output logic [rrlp_pkg::COLOR_W-1:0]       green,
	output logic [rrlp_pkg::COLOR_W-1:0]       blue,
	output logic                               last_pixel,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rrlp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rrlp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rrlp_pkg::*;

	localparam int IDX_W   = $clog2(LED_COUNT);
	localparam int PACE    = LED_COUNT / 2;
	localparam int HALF    = (PACE / 2 > 0) ? PACE / 2 : 1;
	localparam int RND     = HALF / 2;
	localparam int RECIP   = ((1 << RECIP_SHIFT) + HALF - 1) / HALF;
	localparam int KM_W    = RECIP_SHIFT + 2;
	localparam int PROD_W  = KM_W + COLOR_W;
	localparam int RND_M   = RND * RECIP;
	localparam int WRAP_W  = $clog2(9 * LED_COUNT + 1);

	logic [COLOR_W-1:0]      low_q, high_q;
	logic signed [VEL_W-1:0] vel_q [3];
	logic [IDX_W-1:0]        pos_q [3];
	logic [IDX_W-1:0]        pos_nxt [3];
	logic                    toggle_q;
	logic                    active_q;
	logic [IDX_W-1:0]        idx_q;
	logic [COLOR_W-1:0]      bright_q;

	logic                    out_valid_q;
	logic [LED_INDEX_W-1:0]  led_index_q;
	logic [COLOR_W-1:0]      ramp_q [3];
	logic [COLOR_W-1:0]      ramp [3];
	logic                    last_q;

	logic issue, frame_end, take, idx_last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= LOW_BRIGHTNESS_RST;
			high_q   <= HIGH_BRIGHTNESS_RST;
			vel_q[0] <= RED_VEL_RST;
			vel_q[1] <= GREEN_VEL_RST;
			vel_q[2] <= BLUE_VEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOW_BRIGHTNESS:  low_q    <= cfg_data;
				REG_HIGH_BRIGHTNESS: high_q   <= cfg_data;
				REG_RED_VELOCITY:    vel_q[0] <= cfg_data[VEL_W-1:0];
				REG_GREEN_VELOCITY:  vel_q[1] <= cfg_data[VEL_W-1:0];
				REG_BLUE_VELOCITY:   vel_q[2] <= cfg_data[VEL_W-1:0];
				default: ;
			endcase
		end
	end

	// advance each position by its velocity, wrapped round the ring
	always_comb begin
		logic [WRAP_W-1:0] y;
		logic [WRAP_W-1:0] m;
		for (int j = 0; j < 3; j++) begin
			y = WRAP_W'(pos_q[j]) + WRAP_W'(4 * LED_COUNT)
				+ {{(WRAP_W-VEL_W){vel_q[j][VEL_W-1]}}, vel_q[j]};
			for (int s = 3; s >= 0; s--) begin
				m = WRAP_W'(LED_COUNT << s);
				if (y >= m)
					y = y - m;
			end
			pos_nxt[j] = y[IDX_W-1:0];
		end
	end

	assign idx_last   = (idx_q == IDX_W'(LED_COUNT - 1));
	assign issue      = active_q && (!out_valid_q || !pixel_stall);
	assign frame_end  = issue && idx_last;
	assign tick_stall = active_q && !frame_end;
	assign take       = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			pos_q[2] <= '0;
			toggle_q <= 1'b0;
			active_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (take) begin
				if (toggle_q) begin
					pos_q[0] <= pos_nxt[0];
					pos_q[1] <= pos_nxt[1];
					pos_q[2] <= pos_nxt[2];
				end
				toggle_q <= ~toggle_q;
				active_q <= 1'b1;
				idx_q    <= '0;
			end else begin
				if (frame_end)
					active_q <= 1'b0;
				if (issue)
					idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			bright_q <= dim_select ? low_q : high_q;
	end

	// ring index, triangle fold, ramp by reciprocal multiply
	always_comb begin
		logic [IDX_W:0]      rs;
		logic [IDX_W-1:0]    r;
		logic [IDX_W-1:0]    t;
		logic [IDX_W-1:0]    k;
		logic [KM_W-1:0]     km;
		logic [PROD_W-1:0]   prod;
		for (int j = 0; j < 3; j++) begin
			rs = {1'b0, pos_q[j]} + {1'b0, idx_q};
			if (rs >= (IDX_W+1)'(LED_COUNT))
				rs = rs - (IDX_W+1)'(LED_COUNT);
			r = rs[IDX_W-1:0];
			t = (r < IDX_W'(PACE)) ? r : IDX_W'(LED_COUNT - 1) - r;
			if (t > IDX_W'(PACE - 1))
				t = IDX_W'(PACE - 1);
			k = (t < IDX_W'(HALF)) ? '0 : t - IDX_W'(HALF);
			km = KM_W'(k) * KM_W'(RECIP);
			prod = PROD_W'(bright_q) * PROD_W'(km) + PROD_W'(RND_M);
			ramp[j] = prod[RECIP_SHIFT +: COLOR_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (issue)
			out_valid_q <= 1'b1;
		else if (!pixel_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			led_index_q <= LED_INDEX_W'(idx_q);
			ramp_q[0]   <= ramp[0];
			ramp_q[1]   <= ramp[1];
			ramp_q[2]   <= ramp[2];
			last_q      <= idx_last;
		end
	end

	assign pixel_valid = out_valid_q;
	assign led_index   = led_index_q;
	assign red         = ramp_q[0];
	assign green       = ramp_q[1];
	assign blue        = ramp_q[2];
	assign last_pixel  = last_q;

endmodule

[sv/rrlp_checker.sv]
module rrlp_checker #(
	parameter int LED_COUNT = rrlp_pkg::DEFAULT_LED_COUNT
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               tick_valid,
	input logic                               tick_stall,
	input logic                               pixel_valid,
	input logic                               pixel_stall,
	input logic [rrlp_pkg::LED_INDEX_W-1:0]   led_index,
	input logic [rrlp_pkg::COLOR_W-1:0]       red,
	input logic [rrlp_pkg::COLOR_W-1:0]       green,
	input logic [rrlp_pkg::COLOR_W-1:0]       blue,
	input logic                               last_pixel
);
	import rrlp_pkg::*;

	localparam logic [LED_INDEX_W-1:0] LAST_IDX = LED_INDEX_W'(LED_COUNT - 1);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid && $stable(led_index)
			&& $stable(red) && $stable(green) && $stable(blue) && $stable(last_pixel))
		else $error("stalled pixel transaction changed");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> last_pixel == (led_index == LAST_IDX))
		else $error("last_pixel does not match final led_index");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> led_index <= LAST_IDX)
		else $error("led_index beyond ring");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && !tick_stall |=> tick_stall)
		else $error("tick transaction taken while frame just started");

endmodule

bind rotating_ramp_led_pattern rrlp_checker #(.LED_COUNT(LED_COUNT)) u_rrlp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.tick_valid  (tick_valid),
	.tick_stall  (tick_stall),
	.pixel_valid (pixel_valid),
	.pixel_stall (pixel_stall),
	.led_index   (led_index),
	.red         (red),
	.green       (green),
	.blue        (blue),
	.last_pixel  (last_pixel)
);

[tb/tb_rotating_ramp_led_pattern.sv]
`timescale 1ns / 1ps

module tb_rotating_ramp_led_pattern;
	import rrlp_pkg::*;

	localparam int LED_COUNT   = DEFAULT_LED_COUNT;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [LED_INDEX_W-1:0] led;
		logic [COLOR_W-1:0]     r;
		logic [COLOR_W-1:0]     g;
		logic [COLOR_W-1:0]     b;
		logic                   last;
	} pixel_t;

	class led_frame_scoreboard;
		int unsigned low_level;
		int unsigned high_level;
		int          velocity [3];
		int          ring_pos [3];
		bit          advance;
		pixel_t      pixels_due [$];
		int          errors;

		function new();
			low_level   = 32'(LOW_BRIGHTNESS_RST);
			high_level  = 32'(HIGH_BRIGHTNESS_RST);
			velocity[0] = int'($signed(RED_VEL_RST));
			velocity[1] = int'($signed(GREEN_VEL_RST));
			velocity[2] = int'($signed(BLUE_VEL_RST));
			for (int j = 0; j < 3; j++) ring_pos[j] = 0;
			advance = 0;
			errors  = 0;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_LOW_BRIGHTNESS:  low_level   = 32'(data);
				REG_HIGH_BRIGHTNESS: high_level  = 32'(data);
				REG_RED_VELOCITY:    velocity[0] = int'($signed(data[VEL_W-1:0]));
				REG_GREEN_VELOCITY:  velocity[1] = int'($signed(data[VEL_W-1:0]));
				REG_BLUE_VELOCITY:   velocity[2] = int'($signed(data[VEL_W-1:0]));
				default: ;
			endcase
		endfunction

		function int tri_index(int r);
			int pace;
			int t;
			pace = LED_COUNT / 2;
			t = (r < pace) ? r : LED_COUNT - 1 - r;
			if (pace > 0 && t > pace - 1) t = pace - 1;
			return t;
		endfunction

		function logic [COLOR_W-1:0] ramp_level(int unsigned peak, int t);
			int unsigned half;
			int unsigned k;
			int unsigned v;
			half = (LED_COUNT / 4 > 0) ? LED_COUNT / 4 : 1;
			k = (t < half) ? 0 : t - half;
			v = (peak * k + half / 2) / half;
			return v[COLOR_W-1:0];
		endfunction

		function void note_tick(logic sel);
			int unsigned peak;
			int          x;
			pixel_t      px;
			peak = sel ? low_level : high_level;
			if (advance) begin
				for (int j = 0; j < 3; j++) begin
					x = (ring_pos[j] + velocity[j]) % LED_COUNT;
					if (x < 0) x += LED_COUNT;
					ring_pos[j] = x;
				end
			end
			advance = ~advance;
			for (int i = 0; i < LED_COUNT; i++) begin
				px.led  = LED_INDEX_W'(i);
				px.r    = ramp_level(peak, tri_index((ring_pos[0] + i) % LED_COUNT));
				px.g    = ramp_level(peak, tri_index((ring_pos[1] + i) % LED_COUNT));
				px.b    = ramp_level(peak, tri_index((ring_pos[2] + i) % LED_COUNT));
				px.last = (i == LED_COUNT - 1);
				pixels_due.push_back(px);
			end
		endfunction

		task check_pixel(pixel_t got);
			pixel_t want;
			if (pixels_due.size() == 0) begin
				report($sformatf("unexpected pixel led_index=%0d", got.led));
				return;
			end
			want = pixels_due.pop_front();
			if (got.led !== want.led)
				report($sformatf("led_index got %0d want %0d", got.led, want.led));
			if (got.r !== want.r)
				report($sformatf("led %0d red got %0d want %0d", want.led, got.r, want.r));
			if (got.g !== want.g)
				report($sformatf("led %0d green got %0d want %0d", want.led, got.g, want.g));
			if (got.b !== want.b)
				report($sformatf("led %0d blue got %0d want %0d", want.led, got.b, want.b));
			if (got.last !== want.last)
				report($sformatf("led %0d last_pixel got %0b want %0b", want.led, got.last,
					want.last));
		endtask

		function int pending();
			return pixels_due.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   tick_valid = 1'b0;
	logic                   tick_stall;
	logic                   dim_select = 1'b0;
	logic                   pixel_valid;
	logic                   pixel_stall = 1'b0;
	logic [LED_INDEX_W-1:0] led_index;
	logic [COLOR_W-1:0]     red;
	logic [COLOR_W-1:0]     green;
	logic [COLOR_W-1:0]     blue;
	logic                   last_pixel;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	led_frame_scoreboard sb = new();

	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	bit hold_req   = 1'b0;
	int hold_left  = 0;

	rotating_ramp_led_pattern #(.LED_COUNT(LED_COUNT)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_valid  (tick_valid),
		.tick_stall  (tick_stall),
		.dim_select  (dim_select),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.led_index   (led_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last_pixel  (last_pixel),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("** rotating_ramp_led_pattern: FAILED **");
		$finish;
	end

	// sample every transaction on the edge that accepts it
	always @(posedge clk) begin
		pixel_t got;
		if (arst_n) begin
			if (pixel_valid && !pixel_stall) begin
				got.led  = led_index;
				got.r    = red;
				got.g    = green;
				got.b    = blue;
				got.last = last_pixel;
				sb.check_pixel(got);
			end
			if (tick_valid && !tick_stall)
				sb.note_tick(dim_select);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pixel_stall <= 1'b1;
		end else begin
			pixel_stall <= rx_idle_en && ($urandom_range(99) < 15);
		end
	end

	task automatic send_tick(logic sel);
		if (tx_idle_en && $urandom_range(99) < 15) begin
			tick_valid <= 1'b0;
			dim_select <= 1'($urandom_range(1));
			repeat ($urandom_range(40, 1)) @(posedge clk);
		end
		tick_valid <= 1'b1;
		dim_select <= sel;
		@(posedge clk);
		while (tick_stall) @(posedge clk);
	endtask

	task automatic run_ticks(int n);
		for (int i = 0; i < n; i++) send_tick(1'($urandom_range(1)));
	endtask

	// drop valid and wait until every pixel is out
	task automatic settle();
		tick_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (LED_COUNT + 8) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic cfg_close();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_level();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'd255;
			default: return CFG_DATA_W'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_velocity();
		logic [VEL_W-1:0] v;
		case ($urandom_range(5))
			0: v = 5'b10000;
			1: v = 5'b10001;
			2: v = 5'd15;
			3: v = 5'd0;
			default: v = VEL_W'($urandom_range(31));
		endcase
		return {3'($urandom_range(7)), v};
	endfunction

	task automatic random_config();
		if ($urandom_range(9) < 7) cfg_write(REG_LOW_BRIGHTNESS, pick_level());
		if ($urandom_range(9) < 7) cfg_write(REG_HIGH_BRIGHTNESS, pick_level());
		if ($urandom_range(9) < 7) cfg_write(REG_RED_VELOCITY, pick_velocity());
		if ($urandom_range(9) < 7) cfg_write(REG_GREEN_VELOCITY, pick_velocity());
		if ($urandom_range(9) < 7) cfg_write(REG_BLUE_VELOCITY, pick_velocity());
		if ($urandom_range(3) == 0)
			cfg_write(CFG_INDEX_W'($urandom_range(7, 5)), CFG_DATA_W'($urandom_range(255)));
		cfg_write(CFG_INDEX_W'($urandom_range(7)), CFG_DATA_W'($urandom_range(255)));
		cfg_close();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: first frame holds, blue steps backward
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		settle();

		cfg_write(REG_LOW_BRIGHTNESS, 8'd255);
		cfg_write(REG_HIGH_BRIGHTNESS, 8'd0);
		cfg_write(REG_RED_VELOCITY, 8'h0F);
		cfg_write(REG_GREEN_VELOCITY, 8'h10);
		cfg_write(REG_BLUE_VELOCITY, 8'hF1);
		cfg_write(3'd5, 8'hA5);
		cfg_write(3'd6, 8'h5A);
		cfg_write(3'd7, 8'hFF);
		cfg_close();
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		settle();

		cfg_write(REG_LOW_BRIGHTNESS, 8'd1);
		cfg_write(REG_HIGH_BRIGHTNESS, 8'd128);
		cfg_write(REG_RED_VELOCITY, 8'hE0);
		cfg_write(REG_GREEN_VELOCITY, 8'h1F);
		cfg_write(REG_BLUE_VELOCITY, 8'h0E);
		cfg_close();
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		settle();

		for (int phase = 0; phase < 8; phase++) begin
			random_config();
			tx_idle_en = (phase != 1);
			rx_idle_en = (phase != 1);
			if (phase == 4) hold_req = 1'b1;
			run_ticks(33);
			settle();
		end

		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("** rotating_ramp_led_pattern: PASSED **");
		else
			$display("** rotating_ramp_led_pattern: FAILED **");
		$finish;
	end

endmodule
